// ===== rtl/dmct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmct_pkg
// Shared types, operation codes and the frame builder of the multi-channel
// DSHOT transmitter.
// ----------------------------------------------------------------------------
package dmct_pkg;

  localparam int LINE_COUNT = 4;
  localparam logic [10:0] THROTTLE_MAX = 11'd1999;
  localparam logic [11:0] CODE_OFFSET = 12'd48;
  localparam logic [3:0] LAST_BIT = 4'd15;

  // Operation codes as they arrive on the input, plus an internal no-op.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_ZERO_HIGH = 2'd1;
  localparam logic [1:0] REG_PERIOD    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  channel;
    logic        chan_ok;
    logic [15:0] frame;
  } cmd_t;

  typedef struct packed {
    logic [LINE_COUNT-1:0] enable;
    logic [14:0]           zero_high;
    logic [15:0]           period;
  } cfg_t;

  // Code is the throttle plus 48, followed by the telemetry bit and a
  // checksum that XORs the three nibbles of those twelve bits.
  function automatic logic [15:0] build_frame(input logic [10:0] step,
                                              input logic telem);
    logic [10:0] sat;
    logic [11:0] v;
    logic [3:0]  sum;
    sat = (step > THROTTLE_MAX) ? THROTTLE_MAX : step;
    v = (({1'b0, sat} + CODE_OFFSET) << 1) | {11'd0, telem};
    sum = v[3:0] ^ v[7:4] ^ v[11:8];
    return {v, sum};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dshot_multi_channel_transmitter.sv =====
`default_nettype none
// An accepted item is first written into the command queue; the back end then
// executes the queued command and loads the result register when the output
// side is not stalled.
// Throughput: one item per cycle sustained while the output side is not stalled;
// the single execution stage updating the bit timer and frame store sets this figure.
// Reset (synchronous, active high) empties the queue, clears all frames and the
// bit timer, and loads the registers with enable 15, high time 125, period 333.
// ----------------------------------------------------------------------------
// dshot_multi_channel_transmitter
// Multi-channel DSHOT frame transmitter with a decode front, a short command
// queue and an execution back end that drives the line levels.
// ----------------------------------------------------------------------------
module dshot_multi_channel_transmitter import dmct_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  // Input item channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            operation,
  input  wire logic [1:0]            channel,
  input  wire logic [10:0]           throttle_step,
  input  wire logic                  telemetry_request,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [LINE_COUNT-1:0]      line_levels,
  output logic                       busy_res,
  output logic                       frame_end,
  output logic                       rejected
);

  // The register file is always ready to take a write. Software must change the
  // registers only while no transfer is in flight; the block does not enforce
  // this, and the back end reads them directly without any shadowing.
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= 4'hF;
      cfg.zero_high <= 15'd125;
      cfg.period    <= 16'd333;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:    cfg.enable    <= cfg_data[LINE_COUNT-1:0];
        REG_ZERO_HIGH: cfg.zero_high <= cfg_data[14:0];
        REG_PERIOD:    cfg.period    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end decodes each item and builds the frame word of a load, so
  // the checksum logic sits before the queue rather than in the timing path
  // of the execution stage.
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_full;
  logic q_nonempty;
  logic q_pop;
  logic q_push;

  dmct_front #(.CHANNELS(CHANNELS)) u_front (
    .operation         (operation),
    .channel           (channel),
    .throttle_step     (throttle_step),
    .telemetry_request (telemetry_request),
    .cmd               (front_cmd)
  );

  // The input side stalls only when the two-entry queue is full, which
  // happens only after the output side has stalled for a while. In steady
  // flow the queue holds one entry and a transfer happens every cycle.
  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall;

  dmct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_cmd),
    .pop       (q_pop),
    .pop_data  (back_cmd),
    .full      (q_full),
    .nonempty  (q_nonempty)
  );

  // The back end executes one command per cycle whenever its output register
  // is empty or being taken, and the result register decouples the output
  // stall from the queue.
  dmct_back #(.CHANNELS(CHANNELS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (back_cmd),
    .cmd_valid   (q_nonempty),
    .cmd_pop     (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_levels (line_levels),
    .busy_res    (busy_res),
    .frame_end   (frame_end),
    .rejected    (rejected)
  );

endmodule
`default_nettype wire

// ===== rtl/dmct_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmct_front
// Decodes an incoming item into a command and builds the frame word of a load.
// ----------------------------------------------------------------------------
module dmct_front import dmct_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  wire logic [1:0]  operation,
  input  wire logic [1:0]  channel,
  input  wire logic [10:0] throttle_step,
  input  wire logic        telemetry_request,
  output cmd_t             cmd
);

  always_comb begin
    cmd.channel = channel;
    cmd.chan_ok = (32'(channel) < CHANNELS);
    cmd.frame   = build_frame(throttle_step, telemetry_request);
    case (operation)
      OP_LOAD:  cmd.kind = OP_LOAD;
      OP_START: cmd.kind = OP_START;
      OP_TICK:  cmd.kind = OP_TICK;
      default:  cmd.kind = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/dmct_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmct_queue
// Two-entry command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module dmct_queue import dmct_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      full,
  output logic      nonempty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dmct_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmct_back
// Executes commands against the frame store and bit timer, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module dmct_back import dmct_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire cmd_t                  cmd,
  input  wire logic                  cmd_valid,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [LINE_COUNT-1:0]      line_levels,
  output logic                       busy_res,
  output logic                       frame_end,
  output logic                       rejected
);

  localparam int STORE_DEPTH = (CHANNELS < LINE_COUNT) ? CHANNELS : LINE_COUNT;

  logic [15:0] frames [STORE_DEPTH];
  logic [3:0]  bit_position;
  logic [15:0] tick_count;
  logic        sending;

  logic [3:0]  bit_position_next;
  logic [15:0] tick_count_next;
  logic        sending_next;
  logic        fend;
  logic        rej;
  logic [15:0] two_high;
  logic [15:0] period_eff;
  logic [16:0] tick_inc;
  logic [LINE_COUNT-1:0] levels_next;

  assign cmd_pop = cmd_valid && (!out_valid || !out_stall);

  // Effective period: the larger of the period and the one-bit high time,
  // never below one tick.
  always_comb begin
    two_high   = {cfg.zero_high, 1'b0};
    period_eff = (cfg.period > two_high) ? cfg.period : two_high;
    if (period_eff == 16'd0) begin
      period_eff = 16'd1;
    end
    tick_inc = {1'b0, tick_count} + 17'd1;
  end

  always_comb begin
    bit_position_next = bit_position;
    tick_count_next   = tick_count;
    sending_next      = sending;
    fend              = 1'b0;
    rej               = 1'b0;
    case (cmd.kind)
      OP_LOAD: begin
        rej = sending;
      end
      OP_START: begin
        if (sending) begin
          rej = 1'b1;
        end else begin
          sending_next      = 1'b1;
          bit_position_next = 4'd0;
          tick_count_next   = 16'd0;
        end
      end
      OP_TICK: begin
        if (sending) begin
          if (tick_inc >= {1'b0, period_eff}) begin
            tick_count_next = 16'd0;
            if (bit_position == LAST_BIT) begin
              bit_position_next = 4'd0;
              sending_next      = 1'b0;
              fend              = 1'b1;
            end else begin
              bit_position_next = bit_position + 4'd1;
            end
          end else begin
            tick_count_next = tick_inc[15:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Frame store: a load while idle to an existing channel replaces the word of its channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        frames[i] <= 16'd0;
      end
    end else if (cmd_pop && cmd.kind == OP_LOAD && !sending && cmd.chan_ok) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (32'(cmd.channel) == i) begin
          frames[i] <= cmd.frame;
        end
      end
    end
  end

  for (genvar c = 0; c < LINE_COUNT; c++) begin : g_lane
    if (c < STORE_DEPTH) begin : g_on
      logic one_bit;
      logic high;
      assign one_bit = frames[c][LAST_BIT - bit_position_next];
      assign high = (tick_count_next < {1'b0, cfg.zero_high}) ||
                    (one_bit && tick_count_next < two_high);
      assign levels_next[c] = sending_next && cfg.enable[c] && high;
    end else begin : g_off
      assign levels_next[c] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= 4'd0;
      tick_count   <= 16'd0;
      sending      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd_pop) begin
        bit_position <= bit_position_next;
        tick_count   <= tick_count_next;
        sending      <= sending_next;
      end
      out_valid <= cmd_pop || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      line_levels <= levels_next;
      busy_res    <= sending_next;
      frame_end   <= fend;
      rejected    <= rej;
    end
  end

`ifndef SYNTHESIS
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> !busy_res)
    else $error("frame end reported while still busy");
  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> line_levels == '0)
    else $error("line driven while idle");
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res)
    else $error("rejection without a broadcast in progress");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !sending |-> bit_position == 4'd0 && tick_count == 16'd0)
    else $error("bit timer not cleared while idle");
`endif

endmodule
`default_nettype wire
